>>> hdl/grpe_pkg.sv
// Package: shared types, constants and helpers for the glyph row pixel expander.
`default_nettype none

package grpe_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int GLYPH_ROWS = 16;

    localparam int BITS_W  = 8;
    localparam int ROWIN_W = 4;
    localparam int ORG_W   = 12;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 24;
    localparam int CFG_W   = 13;
    localparam int CFG_AW  = 1;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int Y_W    = ORG_W + 1;
    localparam int X_W    = ORG_W + 1;
    localparam int PROD_W = Y_W + DIM_W;

    localparam int PIX_PER_ROW = 8;
    localparam int COL_W       = $clog2(PIX_PER_ROW);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_AW-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BITS_W-1:0]  row_bits;
        logic [ROWIN_W-1:0] row_index;
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [COLOR_W-1:0] foreground;
        logic [COLOR_W-1:0] background;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
        logic               last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } t_cfg;

    // one glyph row, ready for the pixel sequencer
    typedef struct packed {
        logic [BITS_W-1:0]  row_bits;
        logic [ORG_W-1:0]   origin_x;
        logic [ADDR_W-1:0]  row_base;
        logic               row_inside;
        logic [COLOR_W-1:0] foreground;
        logic [COLOR_W-1:0] background;
    } t_job;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // row number wrapped to the glyph height, small constant table
    function automatic logic [ROWIN_W-1:0] row_wrap(input logic [ROWIN_W-1:0] r);
        logic [ROWIN_W-1:0] res;
        res = '0;
        for (int i = 0; i < (1 << ROWIN_W); i++) begin
            if (r == ROWIN_W'(i)) begin
                res = ROWIN_W'(i % GLYPH_ROWS);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/grpe_front.sv
// Front end: takes glyph rows, computes the row base address and vertical clip.
`default_nettype none

module grpe_front
    import grpe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_in,
    output logic          o_q_push,
    input  wire logic     i_q_full,
    output t_job          o_q_data
);

    logic             r_sv, n_sv;
    t_in_item         r_item, n_item;
    logic [Y_W-1:0]   r_y, n_y;
    logic [PROD_W-1:0] prod;
    logic             take;

    assign o_q_push = r_sv && !i_q_full;
    assign o_full   = r_sv && i_q_full;
    assign take     = i_push && !o_full;

    always_comb begin
        n_sv   = r_sv;
        n_item = r_item;
        n_y    = r_y;
        if (take) begin
            n_sv   = 1'b1;
            n_item = i_in;
            n_y    = Y_W'(i_in.origin_y) + Y_W'(row_wrap(i_in.row_index));
        end else if (o_q_push) begin
            n_sv = 1'b0;
        end
    end

    assign prod = PROD_W'(r_y) * PROD_W'(i_cfg.frame_width);

    always_comb begin
        o_q_data.row_bits   = r_item.row_bits;
        o_q_data.origin_x   = r_item.origin_x;
        o_q_data.row_base   = prod[ADDR_W-1:0];
        o_q_data.row_inside = (Y_W + 1)'(r_y) < (Y_W + 1)'(i_cfg.frame_height);
        o_q_data.foreground = r_item.foreground;
        o_q_data.background = r_item.background;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= n_sv;
        end
        r_item <= n_item;
        r_y    <= n_y;
    end

endmodule

`default_nettype wire

>>> hdl/grpe_queue.sv
// Short job queue between the front end and the pixel sequencer.
`default_nettype none

module grpe_queue
    import grpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_data
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [Q_CW-1:0]   r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = r_cnt == Q_CW'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/grpe_back.sv
// Back end: steps through the eight pixels of a row into the output register.
`default_nettype none

module grpe_back
    import grpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_empty,
    input  wire t_job i_q_data,
    output logic      o_q_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out_item o_out
);

    logic             r_bv, n_bv;
    t_job             r_job, n_job;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_ov, n_ov;
    t_out_item        r_out, n_out;

    logic             out_ready, adv, last, load, in_frame;
    logic [X_W-1:0]   x;
    logic [COL_W-1:0] bit_idx;
    t_out_item        pix;

    assign out_ready = !r_ov || i_pop;
    assign adv       = r_bv && out_ready;
    assign last      = r_col == COL_W'(PIX_PER_ROW - 1);
    assign load      = !r_bv || (adv && last);
    assign o_q_pop   = load && !i_q_empty;

    assign x        = X_W'(r_job.origin_x) + X_W'(r_col);
    assign bit_idx  = COL_W'(PIX_PER_ROW - 1) - r_col;
    assign in_frame = r_job.row_inside && ((X_W + 1)'(x) < (X_W + 1)'(i_cfg.frame_width));

    always_comb begin
        pix.pixel_address = in_frame ? (r_job.row_base + ADDR_W'(x)) : '0;
        pix.pixel_color   = r_job.row_bits[bit_idx] ? r_job.foreground : r_job.background;
        pix.write_enable  = in_frame;
        pix.last_pixel    = last;
    end

    always_comb begin
        n_bv  = r_bv;
        n_job = r_job;
        n_col = r_col;
        if (load) begin
            n_bv  = !i_q_empty;
            n_job = i_q_data;
            n_col = '0;
        end else if (adv) begin
            n_col = r_col + 1'b1;
        end
    end

    always_comb begin
        n_ov  = r_ov;
        n_out = r_out;
        if (adv) begin
            n_ov  = 1'b1;
            n_out = pix;
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
    end

    assign o_empty = !r_ov;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv  <= 1'b0;
            r_col <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_bv  <= n_bv;
            r_col <= n_col;
            r_ov  <= n_ov;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

>>> hdl/glyph_row_pixel_expander_top.sv
// Top level: glyph row pixel expander with frame size registers.
//
// Input queue side: present a glyph row on i_in with push; it is taken at an
// edge where push is high and full is low. Each row gives eight pixel
// transactions, leftmost first, the eighth marked last_pixel.
// Result queue side: o_out holds the oldest pixel while empty is low; pop
// takes it. A popped slot refills in the same cycle when a pixel is ready.
// Flow: a taken row is registered in the front stage, written into the job
// queue, loaded into the sequencer, then registered as a pixel on o_out.
// Throughput: one pixel per cycle while pop keeps the output drained, set by
// the single-pixel sequencer in the back end. Rows arriving faster collect in
// the front stage and the two-entry job queue, then full rises.
// Receiver stall: with pop low the output register holds its pixel, the
// sequencer waits, the queue fills and full rises; nothing is dropped.
// Configuration: i_cfg_we writes frame_width (index 0) or frame_height
// (index 1); values above 4096 saturate. Write only while idle.
// Reset (i_rst_n low, synchronous): queues empty, both sizes zero, so all
// pixels come out clipped until the sizes are written.
`default_nettype none

module glyph_row_pixel_expander_top
    import grpe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_in,
    output logic                   empty,
    input  wire logic              pop,
    output t_out_item              o_out
);

    t_cfg r_cfg, n_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_job q_wdata, q_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_FRAME_WIDTH:  n_cfg.frame_width  = clamp_dim(i_cfg_data);
                REG_FRAME_HEIGHT: n_cfg.frame_height = clamp_dim(i_cfg_data);
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    grpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_in     (i_in),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_q_data (q_wdata)
    );

    grpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    grpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

>>> hdl/grpe_checker.sv
// Port-level checker for the glyph row pixel expander, bound to the top level.
`default_nettype none

module grpe_checker
    import grpe_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_full,
    input wire logic      i_empty,
    input wire logic      i_pop,
    input wire t_out_item i_out
);

    logic [COL_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_pop && !i_empty) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (i_empty && !i_full))
        else $error("queues not clear after reset");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_out.write_enable) |-> (i_out.pixel_address == '0))
        else $error("clipped pixel with nonzero address");

    a_last_every_eighth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (i_out.last_pixel == (r_cnt == COL_W'(PIX_PER_ROW - 1))))
        else $error("last_pixel out of step with pixel count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_out)))
        else $error("result changed while stalled");

endmodule

bind glyph_row_pixel_expander_top grpe_checker u_grpe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_full  (full),
    .i_empty (empty),
    .i_pop   (pop),
    .i_out   (o_out)
);

`default_nettype wire

>>> verif/glyph_row_pixel_expander_top_test.sv
// Testbench for the glyph row pixel expander: directed table, random rows, pixel checker.
module glyph_row_pixel_expander_top_test;
    import grpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int PHASES      = 8;
    localparam int ROWS_PER_PH = 32;
    localparam int DIR_ROWS    = 18;

    typedef struct {
        bit          set_size;
        int unsigned wr_w;
        int unsigned wr_h;
        t_in_item    row;
        bit          typed;
        int unsigned addr0;
        logic [7:0]  we_mask;
    } t_dir_row;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                push       = 1'b0;
    logic                full;
    t_in_item            i_in       = '0;
    logic                empty;
    logic                pop        = 1'b0;
    t_out_item           o_out;

    t_out_item   pending_pixels[$];
    int unsigned frame_w_now = 0;
    int unsigned frame_h_now = 0;
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int unsigned rx_cycle    = 0;
    int unsigned rx_mode     = 0;

    t_dir_row dir_tab[DIR_ROWS] = '{
        '{0, 0, 0, '{8'hA5, 4'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0}, 1, 0, 8'h00},
        '{0, 0, 0, '{8'hFF, 4'hF, 12'hFFF, 12'hFFF, 32'h0, 32'hFFFF_FFFF}, 1, 0, 8'h00},
        '{1, 8191, 4096, '{8'h00, 4'd0, 12'd0, 12'd0, 32'h1234_5678, 32'h9ABC_DEF0},
            1, 0, 8'hFF},
        '{0, 0, 0, '{8'h80, 4'hF, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0}, 1, 61440, 8'hFF},
        '{0, 0, 0, '{8'hC3, 4'hF, 12'd4088, 12'd4080, 32'hAAAA_5555, 32'h5555_AAAA},
            1, 16777208, 8'hFF},
        '{0, 0, 0, '{8'h0F, 4'd0, 12'd4092, 12'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0},
            1, 4092, 8'hF0},
        '{0, 0, 0, '{8'hAA, 4'd1, 12'd100, 12'd4095, 32'h1, 32'h2}, 1, 0, 8'h00},
        '{0, 0, 0, '{8'h55, 4'hF, 12'hFFF, 12'hFFF, 32'h3, 32'h4}, 1, 0, 8'h00},
        '{1, 640, 480, '{8'h3C, 4'd9, 12'd636, 12'd470, 32'hDEAD_BEEF, 32'h0BAD_F00D},
            0, 0, 8'h00},
        '{0, 0, 0, '{8'hFF, 4'd0, 12'd0, 12'd479, 32'h7FFF_FFFF, 32'h8000_0000}, 0, 0, 8'h00},
        '{0, 0, 0, '{8'h01, 4'd10, 12'd5, 12'd470, 32'h11, 32'h22}, 0, 0, 8'h00},
        '{1, 0, 4096, '{8'hFF, 4'd0, 12'd0, 12'd0, 32'h33, 32'h44}, 1, 0, 8'h00},
        '{1, 4096, 0, '{8'hFF, 4'd0, 12'd0, 12'd0, 32'h55, 32'h66}, 1, 0, 8'h00},
        '{1, 1, 1, '{8'h80, 4'd0, 12'd0, 12'd0, 32'h77, 32'h88}, 1, 0, 8'h80},
        '{0, 0, 0, '{8'h80, 4'd1, 12'd0, 12'd0, 32'h99, 32'hAA}, 1, 0, 8'h00},
        '{1, 8191, 8191, '{8'h69, 4'hF, 12'd4088, 12'd4080, 32'hCAFE_0001, 32'h0000_CAFE},
            1, 16777208, 8'hFF},
        '{1, 8, 16, '{8'h5A, 4'hF, 12'd0, 12'd0, 32'hBB, 32'hCC}, 1, 120, 8'hFF},
        '{0, 0, 0, '{8'hA5, 4'hF, 12'd1, 12'd0, 32'hDD, 32'hEE}, 1, 121, 8'hFE}
    };

    glyph_row_pixel_expander_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // eight pixels of one glyph row under the current frame size
    function automatic void expand_row(input t_in_item r);
        longint unsigned x;
        longint unsigned y;
        t_out_item       px;
        y = 64'(r.origin_y);
        y += 64'(r.row_index % GLYPH_ROWS);
        for (int c = 0; c < PIX_PER_ROW; c++) begin
            x = 64'(r.origin_x);
            x += 64'(c);
            px.write_enable  = (x < frame_w_now) && (y < frame_h_now);
            px.pixel_address = px.write_enable ? ADDR_W'(y * frame_w_now + x) : '0;
            px.pixel_color   = r.row_bits[7-c] ? r.foreground : r.background;
            px.last_pixel    = (c == PIX_PER_ROW - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic void typed_pixels(input t_in_item r, input int unsigned addr0,
                                         input logic [7:0] we_mask);
        t_out_item px;
        for (int c = 0; c < PIX_PER_ROW; c++) begin
            px.write_enable  = we_mask[7-c];
            px.pixel_address = we_mask[7-c] ? ADDR_W'(addr0 + c) : '0;
            px.pixel_color   = r.row_bits[7-c] ? r.foreground : r.background;
            px.last_pixel    = (c == PIX_PER_ROW - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic logic [ORG_W-1:0] pick_coord(input int unsigned lim,
                                                    input int unsigned span);
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = ((lim > span) ? lim - span : 0) + $urandom_range(0, 2 * span);
            2: v = $urandom_range(0, 31);
            default: v = $urandom_range(4064, 4095);
        endcase
        if (v > 4095) begin
            v = 4095;
        end
        return ORG_W'(v);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic send_row(input t_in_item r, input bit typed, input int unsigned addr0,
                            input logic [7:0] we_mask);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_in <= r;
        do @(posedge i_clk); while (full);
        if (typed) begin
            typed_pixels(r, addr0, we_mask);
        end else begin
            expand_row(r);
        end
    endtask

    task automatic write_sizes(input int unsigned w, input int unsigned h);
        push <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_FRAME_WIDTH;
        i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_addr <= REG_FRAME_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_w_now = fit_dim(CFG_W'(w));
        frame_h_now = fit_dim(CFG_W'(h));
    endtask

    // pixel checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("transaction with nothing pending, address",
                                o_out.pixel_address, 0);
            end else begin
                if (o_out.pixel_address !== pending_pixels[0].pixel_address)
                    report_mismatch("pixel_address", o_out.pixel_address,
                                    pending_pixels[0].pixel_address);
                if (o_out.pixel_color !== pending_pixels[0].pixel_color)
                    report_mismatch("pixel_color", o_out.pixel_color,
                                    pending_pixels[0].pixel_color);
                if (o_out.write_enable !== pending_pixels[0].write_enable)
                    report_mismatch("write_enable", o_out.write_enable,
                                    pending_pixels[0].write_enable);
                if (o_out.last_pixel !== pending_pixels[0].last_pixel)
                    report_mismatch("last_pixel", o_out.last_pixel,
                                    pending_pixels[0].last_pixel);
                void'(pending_pixels.pop_front());
            end
        end
        if (rx_cycle % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        rx_cycle++;
        case (rx_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= rx_cycle[3];
        endcase
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_in_item    r;
        int unsigned w;
        int unsigned h;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].set_size) begin
                write_sizes(dir_tab[k].wr_w, dir_tab[k].wr_h);
            end
            send_row(dir_tab[k].row, dir_tab[k].typed, dir_tab[k].addr0, dir_tab[k].we_mask);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin w = 4096; h = 4096; end
                1: begin w = 640; h = 480; end
                2: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
                3: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
                4: begin w = 0; h = $urandom_range(0, 4096); end
                5: begin w = $urandom_range(0, 4096); h = 0; end
                6: begin w = 8191; h = 8191; end
                default: begin w = $urandom_range(100, 4096); h = $urandom_range(1, 4096); end
            endcase
            write_sizes(w, h);
            for (int n = 0; n < ROWS_PER_PH; n++) begin
                case ($urandom_range(0, 5))
                    0: r.row_bits = 8'h00;
                    1: r.row_bits = 8'hFF;
                    default: r.row_bits = BITS_W'($urandom_range(0, 255));
                endcase
                r.row_index  = ROWIN_W'($urandom_range(0, 15));
                r.origin_x   = pick_coord(frame_w_now, 8);
                r.origin_y   = pick_coord(frame_h_now, 16);
                r.foreground = $urandom;
                r.background = $urandom;
                send_row(r, 1'b0, 0, 8'h00);
            end
        end

        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
